[sv/slew_limited_motor_command_macros.svh]
// ----------------------------------------------------------------------------
// Slew-limited motor command assertion macros
// Shared property forms for the checker, sampled on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef SLEW_LIMITED_MOTOR_COMMAND_MACROS_SVH
`define SLEW_LIMITED_MOTOR_COMMAND_MACROS_SVH

// Same-cycle implication.
`define SLMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/slmc_pkg.sv]
// ----------------------------------------------------------------------------
// Slew-limited motor command package
// Word types, command codes and register indexes shared by the block.
// ----------------------------------------------------------------------------
package slmc_pkg;

  localparam int POWER_W = 16;
  localparam int WIDE_W  = POWER_W + 2;
  localparam int STEP_W  = 15;
  localparam int CMD_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PRESET_N   = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 4'd0,
    CMD_DEMAND   = 4'd1,
    CMD_RAISE    = 4'd2,
    CMD_LOWER    = 4'd3,
    CMD_HALT     = 4'd4,
    CMD_PRESET_A = 4'd5,
    CMD_PRESET_B = 4'd6,
    CMD_PRESET_C = 4'd7,
    CMD_PRESET_D = 4'd8,
    CMD_ZERO_ALL = 4'd9
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LEVEL     = 3'd0,
    REG_MAX_LEVEL     = 3'd1,
    REG_MAX_SLEW_STEP = 3'd2,
    REG_RAISE_STEP    = 3'd3,
    REG_LOWER_STEP    = 3'd4,
    REG_PRESET_LEVELS = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        [CMD_W-1:0]   cmd;
    logic signed [POWER_W-1:0] analog_value;
    logic                      button_pressed;
    logic                      top_switch;
    logic                      bottom_switch;
  } in_word_t;

  typedef struct packed {
    logic signed [POWER_W-1:0] command_power;
    logic signed [POWER_W-1:0] target_power;
  } out_word_t;

  typedef struct packed {
    logic signed [POWER_W-1:0]             min_level;
    logic signed [POWER_W-1:0]             max_level;
    logic        [STEP_W-1:0]              max_slew_step;
    logic        [STEP_W-1:0]              raise_step;
    logic        [STEP_W-1:0]              lower_step;
    logic [PRESET_N-1:0][POWER_W-1:0]      preset_levels;
  } cfg_t;

endpackage

[sv/slmc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Slew-limited motor command configuration registers
// Holds the limits, step sizes and presets written through the write port.
// ----------------------------------------------------------------------------
module slmc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [slmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slmc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output slmc_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_level     <= -16'sd16384;
      cfg.max_level     <= 16'sd16384;
      cfg.max_slew_step <= 15'd4096;
      cfg.raise_step    <= 15'd1638;
      cfg.lower_step    <= 15'd1638;
      cfg.preset_levels <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slmc_pkg::REG_MIN_LEVEL: begin
          cfg.min_level <= $signed(cfg_data[slmc_pkg::POWER_W-1:0]);
        end
        slmc_pkg::REG_MAX_LEVEL: begin
          cfg.max_level <= $signed(cfg_data[slmc_pkg::POWER_W-1:0]);
        end
        slmc_pkg::REG_MAX_SLEW_STEP: begin
          cfg.max_slew_step <= cfg_data[slmc_pkg::STEP_W-1:0];
        end
        slmc_pkg::REG_RAISE_STEP: begin
          cfg.raise_step <= cfg_data[slmc_pkg::STEP_W-1:0];
        end
        slmc_pkg::REG_LOWER_STEP: begin
          cfg.lower_step <= cfg_data[slmc_pkg::STEP_W-1:0];
        end
        slmc_pkg::REG_PRESET_LEVELS: begin
          cfg.preset_levels <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[sv/slmc_update.sv]
// ----------------------------------------------------------------------------
// Slew-limited motor command update logic
// Computes the next target and command power for one registered item.
// ----------------------------------------------------------------------------
module slmc_update (
  input  slmc_pkg::in_word_t                        item,
  input  slmc_pkg::cfg_t                            cfg,
  input  logic signed [slmc_pkg::POWER_W-1:0]       target,
  input  logic signed [slmc_pkg::POWER_W-1:0]       command,
  output logic signed [slmc_pkg::POWER_W-1:0]       target_next,
  output logic signed [slmc_pkg::POWER_W-1:0]       command_next
);

  localparam int W  = slmc_pkg::WIDE_W;
  localparam int PW = slmc_pkg::POWER_W;
  localparam logic signed [W-1:0] FIT_HI = W'((1 << (PW - 1)) - 1);
  localparam logic signed [W-1:0] FIT_LO = ~FIT_HI;

  function automatic logic signed [W-1:0] clamp_wide(input logic signed [W-1:0] lo,
                                                     input logic signed [W-1:0] hi,
                                                     input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [PW-1:0] fit(input logic signed [W-1:0] v);
    logic signed [W-1:0] r;
    r = clamp_wide(FIT_LO, FIT_HI, v);
    return r[PW-1:0];
  endfunction

  logic signed [W-1:0] tgt_w;
  logic signed [W-1:0] cmd_w;
  logic signed [W-1:0] min_w;
  logic signed [W-1:0] max_w;
  logic signed [W-1:0] slew_w;
  logic signed [W-1:0] raise_w;
  logic signed [W-1:0] lower_w;
  logic signed [W-1:0] analog_w;
  logic signed [W-1:0] preset_w;
  logic signed [W-1:0] cmd_up;
  logic signed [W-1:0] cmd_dn;
  logic signed [W-1:0] slewed;
  logic signed [W-1:0] upper_clamped;
  logic signed [W-1:0] lower_clamped;
  logic signed [W-1:0] tgt_new;
  logic signed [W-1:0] cmd_new;
  logic [1:0]          preset_sel;

  assign tgt_w    = W'(target);
  assign cmd_w    = W'(command);
  assign min_w    = W'($signed(cfg.min_level));
  assign max_w    = W'($signed(cfg.max_level));
  assign slew_w   = $signed(W'(cfg.max_slew_step));
  assign raise_w  = $signed(W'(cfg.raise_step));
  assign lower_w  = $signed(W'(cfg.lower_step));
  assign analog_w = W'($signed(item.analog_value));

  assign preset_sel = 2'(item.cmd - slmc_pkg::CMD_PRESET_A);
  assign preset_w   = W'($signed(cfg.preset_levels[preset_sel]));

  assign cmd_up = cmd_w + slew_w;
  assign cmd_dn = cmd_w - slew_w;

  always_comb begin
    if (tgt_w > cmd_up) begin
      slewed = cmd_up;
    end else if (tgt_w < cmd_dn) begin
      slewed = cmd_dn;
    end else begin
      slewed = tgt_w;
    end
    upper_clamped = item.top_switch ? clamp_wide(min_w, '0, slewed) : slewed;
    lower_clamped = item.bottom_switch ? clamp_wide('0, max_w, upper_clamped)
                                       : upper_clamped;
  end

  always_comb begin
    tgt_new = tgt_w;
    cmd_new = cmd_w;
    case (item.cmd) inside
      slmc_pkg::CMD_TICK: begin
        cmd_new = lower_clamped;
      end
      slmc_pkg::CMD_DEMAND: begin
        tgt_new = clamp_wide(min_w, max_w, analog_w);
      end
      slmc_pkg::CMD_RAISE: begin
        if (item.button_pressed) begin
          tgt_new = clamp_wide(min_w, max_w, tgt_w + raise_w);
        end
      end
      slmc_pkg::CMD_LOWER: begin
        if (item.button_pressed) begin
          tgt_new = clamp_wide(min_w, max_w, tgt_w - lower_w);
        end
      end
      slmc_pkg::CMD_HALT: begin
        if (item.button_pressed) begin
          tgt_new = '0;
        end
      end
      slmc_pkg::CMD_PRESET_A, slmc_pkg::CMD_PRESET_B,
      slmc_pkg::CMD_PRESET_C, slmc_pkg::CMD_PRESET_D: begin
        tgt_new = item.button_pressed ? clamp_wide(min_w, max_w, preset_w) : '0;
      end
      slmc_pkg::CMD_ZERO_ALL: begin
        tgt_new = '0;
        cmd_new = '0;
      end
      default: begin
      end
    endcase
  end

  assign target_next  = fit(tgt_new);
  assign command_next = fit(cmd_new);

endmodule

[sv/slew_limited_motor_command.sv]
// ----------------------------------------------------------------------------
// Slew-limited motor command
// Operator items set a target power; tick items slew the command power toward
// it, honoring the limit switches. Every item returns both powers.
// ----------------------------------------------------------------------------
// Items arrive on item/item_valid and are taken when item_stall is low.
// Each item gives one result word on result/result_valid, held until the
// receiver drops result_stall.
// An accepted item is registered, processed against the stored target and
// command power, and its result word is registered once the result word is
// free to change. One item is taken every cycle as long as the receiver keeps
// up; the two power registers update as each result word is registered.
// While the receiver stalls, the result word holds and a full item register
// holds; item_stall is high while the item register is full and the result
// word is stalled.
// Reset clears both powers and all valid flags and loads the register
// defaults; configuration is written through cfg_we, cfg_index and cfg_data,
// only by the user while no item is in flight; not enforced by the block.
// ----------------------------------------------------------------------------
module slew_limited_motor_command (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  slmc_pkg::in_word_t                  item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output slmc_pkg::out_word_t                 result,
  input  logic                                cfg_we,
  input  logic [slmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  slmc_pkg::cfg_t                        cfg;
  slmc_pkg::in_word_t                    held;
  logic                                  held_valid;
  logic                                  out_ready;
  logic                                  advance;
  logic signed [slmc_pkg::POWER_W-1:0]   target;
  logic signed [slmc_pkg::POWER_W-1:0]   command;
  logic signed [slmc_pkg::POWER_W-1:0]   target_next;
  logic signed [slmc_pkg::POWER_W-1:0]   command_next;

  slmc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slmc_update u_update (
    .item         (held),
    .cfg          (cfg),
    .target       (target),
    .command      (command),
    .target_next  (target_next),
    .command_next (command_next)
  );

  assign out_ready  = !result_valid || !result_stall;
  assign advance    = held_valid && out_ready;
  assign item_stall = held_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
      target       <= '0;
      command      <= '0;
    end else begin
      if (!item_stall) begin
        held_valid <= item_valid;
      end
      if (out_ready) begin
        result_valid <= held_valid;
      end
      if (advance) begin
        target  <= target_next;
        command <= command_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      held <= item;
    end
    if (advance) begin
      result.command_power <= command_next;
      result.target_power  <= target_next;
    end
  end

endmodule

[sv/slmc_checker.sv]
// ----------------------------------------------------------------------------
// Slew-limited motor command port checker
// Watches the item and result channels of the top level over time.
// ----------------------------------------------------------------------------
`include "slew_limited_motor_command_macros.svh"

module slmc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_stall,
  input logic                 result_valid,
  input logic                 result_stall,
  input slmc_pkg::out_word_t  result
);

  `SLMC_ASSERT_NEXT(a_result_holds, result_valid && result_stall, result_valid && $stable(result), "result word changed while stalled")
  `SLMC_ASSERT_NOW(a_no_result_after_reset, $past(rst), !result_valid, "result valid right after reset")
  `SLMC_ASSERT_NOW(a_stall_only_on_backpressure, item_stall, result_valid && result_stall, "item stalled without output backpressure")
  `SLMC_ASSERT_NEXT(a_result_follows_item, (item_valid && !item_stall) ##1 !result_stall, result_valid, "accepted item gave no result")

endmodule

bind slew_limited_motor_command slmc_checker u_slmc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
